### src/tsg_pkg.sv
// Shared types and constants for the trapezoid step generator.
package tsg_pkg;

	localparam int unsigned CountW = 24;
	localparam int unsigned VelW   = 32;
	localparam int unsigned DeltaW = 25;
	localparam int unsigned QuoW   = 2 * VelW - (VelW + 1);
	localparam int unsigned DivN   = QuoW;
	localparam int unsigned SqrtN  = VelW;
	localparam int unsigned CntW   = 6;
	localparam int unsigned AddrW  = 4;
	localparam int unsigned OutW   = 72;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_ABORT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_START_VEL = 2'd0,
		REG_MAX_VEL   = 2'd1,
		REG_ACCEL     = 2'd2,
		REG_INVERT    = 2'd3
	} reg_idx_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_MUL2 = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef struct packed {
		logic in_load;
		logic sq_load;
		logic div_step;
		logic mul2_load;
		logic sqrt_step;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_start;
		logic zero_len;
		logic triangle;
	} stat_t;

	typedef struct packed {
		logic [VelW-1:0] start_vel;
		logic [VelW-1:0] max_vel;
		logic [VelW-1:0] accel;
		logic            invert;
	} cfg_t;

endpackage

### src/tsg_regs.sv
// Configuration register file behind the APB-style port.
module tsg_regs import tsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_vel <= '0;
			cfg_q.max_vel   <= '0;
			cfg_q.accel     <= VelW'(1);
			cfg_q.invert    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_START_VEL: cfg_q.start_vel <= pwdata;
				REG_MAX_VEL:   cfg_q.max_vel   <= pwdata;
				REG_ACCEL:     cfg_q.accel     <= pwdata;
				REG_INVERT:    cfg_q.invert    <= pwdata[0];
				default:       cfg_q.invert    <= cfg_q.invert;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_VEL: prdata = cfg_q.start_vel;
			REG_MAX_VEL:   prdata = cfg_q.max_vel;
			REG_ACCEL:     prdata = cfg_q.accel;
			REG_INVERT:    prdata = {31'd0, cfg_q.invert};
			default:       prdata = '0;
		endcase
	end

endmodule

### src/tsg_ctrl.sv
// Controller: item sequencing, plan iterations and output word handshake.
module tsg_ctrl import tsg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t          state_q;
	logic [CntW-1:0] cnt_q;
	logic            ovalid_q;
	logic            out_free;
	logic            accept;

	assign out_free = !ovalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = ovalid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_load  = accept;
				cmd.out_load = accept && !(stat.is_start && !stat.zero_len);
			end
			ST_MUL:  cmd.sq_load = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_MUL2: cmd.mul2_load = 1'b1;
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_FIN: begin
				cmd.commit   = out_free;
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept && stat.is_start && !stat.zero_len) state_q <= ST_MUL;
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(DivN - 1)) begin
						// quotient complete on entry to ST_MUL2, where the triangle check is made
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					cnt_q   <= '0;
					state_q <= stat.triangle ? ST_SQRT : ST_FIN;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(SqrtN - 1)) state_q <= ST_FIN;
				end
				ST_FIN: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/tsg_dp.sv
// Datapath: profile state, tick update, divider and square root for planning.
module tsg_dp import tsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic [1:0]        op_in,
	input  logic [DeltaW-1:0] delta_in,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic [OutW-1:0]   out_word
);

	logic [VelW-1:0]   cur_q, phase_q, peak_q, pos_q;
	logic [CountW-1:0] steps_q, target_q, adist_q;
	logic              fwd_q, busy_q;

	logic [QuoW-1:0]   quo_q;
	logic [VelW-1:0]   drem_q;
	logic [2*VelW-1:0] rad_q;
	logic [VelW+1:0]   srem_q;
	logic [VelW-1:0]   root_q;
	logic [OutW-1:0]   out_q;

	logic [VelW-1:0]   a, floor_v;
	op_t               op;
	logic              neg;
	logic [DeltaW-1:0] mag25;
	logic [CountW-1:0] mag;

	// next-state values
	logic [VelW-1:0]   n_cur, n_phase, n_peak, n_pos;
	logic [CountW-1:0] n_steps, n_target, n_adist;
	logic              n_fwd, n_busy, n_pulse, n_done;

	logic [VelW:0]     vt, sum;
	logic [VelW:0]     dt;
	logic [VelW+3:0]   sr, trial;
	logic [2*VelW-1:0] sq;
	logic [VelW+CountW-1:0] p2;

	assign a       = (cfg.accel != '0) ? cfg.accel : VelW'(1);
	assign floor_v = (cfg.start_vel != '0) ? cfg.start_vel : VelW'(1);
	assign op      = op_t'(op_in);
	assign neg     = delta_in[DeltaW-1];
	assign mag25   = neg ? (~delta_in + 1'b1) : {1'b0, delta_in[DeltaW-2:0]};
	assign mag     = mag25[DeltaW-1] ? {CountW{1'b1}} : mag25[CountW-1:0];

	assign stat.is_start = (op == OP_START);
	assign stat.zero_len = (mag == '0);
	assign stat.triangle = ({quo_q, 1'b0} > (QuoW + 1)'(target_q));

	assign sq = cfg.max_vel * cfg.max_vel;
	assign p2 = a * {target_q[CountW-1:1], 1'b0};
	assign dt = {drem_q, quo_q[QuoW-1]};
	assign sr = {srem_q, rad_q[2*VelW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	always_comb begin
		n_cur = cur_q; n_phase = phase_q; n_peak = peak_q; n_pos = pos_q;
		n_steps = steps_q; n_target = target_q; n_adist = adist_q;
		n_fwd = fwd_q; n_busy = busy_q; n_pulse = 1'b0; n_done = 1'b0;
		vt = '0; sum = '0;
		if (cmd.in_load) begin
			unique case (op)
				OP_START: begin
					n_cur = '0; n_phase = '0; n_steps = '0; n_adist = '0;
					n_peak = '0; n_busy = 1'b0; n_target = '0;
					n_fwd = !neg;
					if (mag != '0) n_target = mag;
				end
				OP_ABORT: begin
					n_cur = '0; n_phase = '0; n_steps = '0; n_target = '0;
					n_adist = '0; n_peak = '0; n_busy = 1'b0;
				end
				OP_TICK: if (busy_q) begin
					if (steps_q <= adist_q) begin
						vt = {1'b0, cur_q} + {1'b0, a};
						if (vt > {1'b0, peak_q}) vt = {1'b0, peak_q};
					end else if (steps_q <= target_q - adist_q) begin
						vt = {1'b0, peak_q};
					end else begin
						vt = (cur_q > a) ? {1'b0, cur_q - a} : '0;
					end
					if (vt < {1'b0, floor_v}) vt = {1'b0, floor_v};
					n_cur = vt[VelW-1:0];
					sum = {1'b0, phase_q} + {1'b0, n_cur};
					n_pulse = sum[VelW];
					n_phase = sum[VelW-1:0];
					if (n_pulse) begin
						n_pos   = fwd_q ? pos_q + 1'b1 : pos_q - 1'b1;
						n_steps = steps_q + 1'b1;
						if (n_steps >= target_q) begin
							n_done = 1'b1; n_busy = 1'b0;
							n_cur = '0; n_phase = '0;
						end
					end
				end
				default: n_busy = busy_q;
			endcase
		end else if (cmd.commit) begin
			if (stat.triangle) begin
				n_adist = {1'b0, target_q[CountW-1:1]};
				n_peak  = root_q;
			end else begin
				n_adist = quo_q[CountW-1:0];
				n_peak  = cfg.max_vel;
			end
			n_cur  = cfg.start_vel;
			n_busy = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0; phase_q <= '0; peak_q <= '0; pos_q <= '0;
			steps_q <= '0; target_q <= '0; adist_q <= '0;
			fwd_q <= 1'b1; busy_q <= 1'b0;
		end else begin
			cur_q <= n_cur; phase_q <= n_phase; peak_q <= n_peak; pos_q <= n_pos;
			steps_q <= n_steps; target_q <= n_target; adist_q <= n_adist;
			fwd_q <= n_fwd; busy_q <= n_busy;
		end
	end

	// divider: floor((vmax^2 >> 33) / a), one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			quo_q  <= sq[2*VelW-1 -: QuoW];
			drem_q <= '0;
		end else if (cmd.div_step) begin
			if (dt >= {1'b0, a}) begin
				drem_q <= VelW'(dt - {1'b0, a});
				quo_q  <= {quo_q[QuoW-2:0], 1'b1};
			end else begin
				drem_q <= dt[VelW-1:0];
				quo_q  <= {quo_q[QuoW-2:0], 1'b0};
			end
		end
	end

	// square root of low32(a * (d with bit 0 cleared)) << 32, two radicand bits per cycle
	always_ff @(posedge clk) begin
		if (cmd.mul2_load) begin
			rad_q  <= {p2[VelW-1:0], {VelW{1'b0}}};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[2*VelW-3:0], 2'b00};
			if (sr >= trial) begin
				srem_q <= (VelW + 2)'(sr - trial);
				root_q <= {root_q[VelW-2:0], 1'b1};
			end else begin
				srem_q <= sr[VelW+1:0];
				root_q <= {root_q[VelW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= {4'd0, n_cur, n_pos, n_done, n_busy, n_fwd ^ cfg.invert, n_pulse};
	end

	assign out_word = out_q;

endmodule

### src/trapezoid_step_generator.sv
// Top level of the trapezoid step generator.
// One stepper axis. Input words on s_*: s_tuser carries the opcode (tick, start,
// abort), s_tdata the signed step delta of a start. Every input word gives one
// output word on m_*: step pulse, direction pin, moving, move done, position
// and velocity, showing the state after the word.
// Tick, abort and no-op words need no planning; a word can be accepted every
// cycle while the output side keeps up, since the result is registered.
// A start with a nonzero delta plans the profile in the states ST_MUL
// (multiply), ST_DIV (divider steps, one quotient bit each), ST_MUL2
// (multiply), then ST_SQRT (square root) for a triangle profile only, and
// ST_FIN (commit), which loads the output word once it is free. No input
// is taken during planning. When m_tready is low the output word holds and
// s_tready drops until it is taken. Reset clears the move, position and
// registers (accel to 1) and sets the direction forward. Registers must be
// written over APB only while idle; the block itself does not enforce this.
module trapezoid_step_generator import tsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // [24:0] move_delta
	input  logic [1:0]       s_tuser,  // [1:0] opcode
	output logic             m_tvalid,
	input  logic             m_tready,
	// [0] step_pulse, [1] direction_pin, [2] moving, [3] move_done,
	// [35:4] position, [67:36] velocity
	output logic [OutW-1:0]  m_tdata,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;

	tsg_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	tsg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .cmd(cmd)
	);

	tsg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .op_in(s_tuser),
		.delta_in(s_tdata[DeltaW-1:0]), .cmd(cmd), .stat(stat), .out_word(m_tdata)
	);

endmodule
